// ----- hdl/sek_pkg.sv -----
// ----------------------------------------------------------------------------
// sek_pkg
// Shared types and constants of the squared exponential kernel pipeline.
// ----------------------------------------------------------------------------
package sek_pkg;

  // coordinates per point in hardware
  localparam int NDIM = 4;
  // result slots per item: amplitude term plus one per dimension
  localparam int NRES = NDIM + 1;

  localparam int VAL_W  = 40;
  localparam int SMAG_W = 32;
  localparam int ZD_W   = 32;
  localparam int W_W    = 40;
  localparam int Z_W    = 34;
  localparam int K_W    = 37;
  localparam int S2_W   = 36;
  localparam int E_W    = 17;

  // item modes
  localparam logic [1:0] MODE_VALUE = 2'd0;
  localparam logic [1:0] MODE_HYPER = 2'd1;
  localparam logic [1:0] MODE_INPUT = 2'd2;

  // register indexes
  localparam logic [2:0] REG_AMP  = 3'd0;
  localparam logic [2:0] REG_INV0 = 3'd1;
  localparam logic [2:0] REG_INVL = 3'd4;

  // log2(e) in Q.16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // horner coefficients of 2^-f, Q16, index 0 innermost
  localparam logic [3:0][15:0] HORNER_C = {16'd45426, 16'd15743, 16'd3638, 16'd630};

  // item state travelling down the pipeline
  typedef struct packed {
    logic [1:0]                  mode;
    logic [NDIM-1:0]             dneg;
    logic [NDIM-1:0][ZD_W-1:0]   zd;
    logic [NDIM-1:0][W_W-1:0]    w;
  } item_t;

  // finished result set of one item
  typedef struct packed {
    logic [1:0]                  mode;
    logic [NRES-1:0][VAL_W-1:0]  vals;
  } res_t;

endpackage

// ----- hdl/sek_front.sv -----
// ----------------------------------------------------------------------------
// sek_front
// Input register, scaled differences, squared terms and their sum.
// ----------------------------------------------------------------------------
module sek_front
  import sek_pkg::*;
#(
  parameter int ND = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [1:0]                  mode_i,
  input  logic [NDIM-1:0][15:0]       pa_i,
  input  logic [NDIM-1:0][15:0]       pb_i,
  input  logic [NDIM-1:0][23:0]       inv_i,
  output logic                        vld_o,
  output item_t                       item_o,
  output logic [Z_W-1:0]              z_o
);

  logic                          v0_q, v1_q, v2_q, v3_q;
  logic [1:0]                    mode0_q, mode1_q;
  logic [NDIM-1:0][15:0]         pa_q, pb_q;
  logic [NDIM-1:0][SMAG_W-1:0]   smag1_q;
  logic [NDIM-1:0]               dneg1_q;
  item_t                         item2_q, item3_q;
  logic [Z_W-1:0]                z3_q;

  logic [NDIM-1:0][16:0]         delta;
  logic [NDIM-1:0][16:0]         mag;
  logic [NDIM-1:0]               neg;
  logic [NDIM-1:0][39:0]         prod1;
  logic [NDIM-1:0][47:0]         sq2;
  logic [NDIM-1:0][55:0]         wp2;
  item_t                         item2_d;
  logic [Z_W-1:0]                z3_d;

  // difference magnitude times inverse length
  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      delta[d] = {pa_q[d][15], pa_q[d]} - {pb_q[d][15], pb_q[d]};
      neg[d]   = delta[d][16];
      mag[d]   = neg[d] ? (17'd0 - delta[d]) : delta[d];
      prod1[d] = 40'(mag[d][15:0]) * 40'(inv_i[d]);
    end
  end

  // squared term with saturation, and input gradient weight
  always_comb begin
    item2_d.mode = mode1_q;
    item2_d.dneg = dneg1_q;
    for (int d = 0; d < NDIM; d++) begin
      sq2[d] = 48'(smag1_q[d][23:0]) * 48'(smag1_q[d][23:0]);
      wp2[d] = 56'(smag1_q[d]) * 56'(inv_i[d]);
      item2_d.zd[d] = (|smag1_q[d][31:24]) ? {ZD_W{1'b1}} : sq2[d][47:16];
      item2_d.w[d]  = wp2[d][55:16];
    end
  end

  // sum over the dimensions in use
  always_comb begin
    z3_d = '0;
    for (int d = 0; d < NDIM; d++) begin
      if (d < ND) begin
        z3_d = z3_d + Z_W'(item2_q.zd[d]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode0_q <= mode_i;
      pa_q    <= pa_i;
      pb_q    <= pb_i;
      mode1_q <= mode0_q;
      dneg1_q <= neg;
      for (int d = 0; d < NDIM; d++) begin
        smag1_q[d] <= prod1[d][39:8];
      end
      item2_q <= item2_d;
      item3_q <= item2_q;
      z3_q    <= z3_d;
    end
  end

  assign vld_o  = v3_q;
  assign item_o = item3_q;
  assign z_o    = z3_q;

endmodule

// ----- hdl/sek_exp.sv -----
// ----------------------------------------------------------------------------
// sek_exp
// exp(-z/2) in Q1.16: base-2 split, four horner steps, final shift.
// ----------------------------------------------------------------------------
module sek_exp
  import sek_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  item_t           item_i,
  input  logic [Z_W-1:0]  z_i,
  output logic            vld_o,
  output item_t           item_o,
  output logic [E_W-1:0]  e_o
);

  logic        v4_q, v5_q, v6_q, v7_q, v8_q;
  item_t       item4_q, item5_q, item6_q, item7_q, item8_q;
  logic [15:0] f4_q, f5_q, f6_q, f7_q;
  logic [4:0]  n4_q, n5_q, n6_q, n7_q;
  logic        zr4_q, zr5_q, zr6_q, zr7_q;
  logic [15:0] p5_q, p6_q, p7_q;
  logic [E_W-1:0] e8_q;

  logic [49:0] y;
  logic [17:0] n_full;
  logic [31:0] m5, m6, m7, m8;
  logic [16:0] r8;

  // exponent split: y = (z/2) * log2(e)
  assign y      = 50'(z_i[Z_W-1:1]) * 50'(LOG2E_Q16);
  assign n_full = y[49:32];

  // horner products
  assign m5 = 32'(HORNER_C[0]) * 32'(f4_q);
  assign m6 = 32'(p5_q) * 32'(f5_q);
  assign m7 = 32'(p6_q) * 32'(f6_q);
  assign m8 = 32'(p7_q) * 32'(f7_q);
  assign r8 = 17'd65536 - 17'(m8[31:16]);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= vld_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item4_q <= item_i;
      f4_q    <= y[31:16];
      n4_q    <= n_full[4:0];
      zr4_q   <= (n_full >= 18'd17);

      item5_q <= item4_q;
      f5_q    <= f4_q;
      n5_q    <= n4_q;
      zr5_q   <= zr4_q;
      p5_q    <= HORNER_C[1] - m5[31:16];

      item6_q <= item5_q;
      f6_q    <= f5_q;
      n6_q    <= n5_q;
      zr6_q   <= zr5_q;
      p6_q    <= HORNER_C[2] - m6[31:16];

      item7_q <= item6_q;
      f7_q    <= f6_q;
      n7_q    <= n6_q;
      zr7_q   <= zr6_q;
      p7_q    <= HORNER_C[3] - m7[31:16];

      item8_q <= item7_q;
      e8_q    <= zr7_q ? '0 : (r8 >> n7_q);
    end
  end

  assign vld_o  = v8_q;
  assign item_o = item8_q;
  assign e_o    = e8_q;

endmodule

// ----- hdl/sek_grad.sv -----
// ----------------------------------------------------------------------------
// sek_grad
// Kernel value and gradient components with saturation to Q23.16.
// ----------------------------------------------------------------------------
module sek_grad
  import sek_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  item_t            item_i,
  input  logic [E_W-1:0]   e_i,
  input  logic [S2_W-1:0]  s2_i,
  output logic             vld_o,
  output res_t             res_o
);

  localparam logic [60:0] VMAX = 61'h7FFFFFFFFF;

  logic                    v9_q, v10_q, v11_q;
  item_t                   item9_q;
  logic [K_W-1:0]          k9_q, k10_q;
  logic [1:0]              mode10_q;
  logic [NDIM-1:0]         dneg10_q;
  logic [NDIM-1:0][39:0]   ll_q;
  logic [NDIM-1:0][44:0]   lh_q;
  logic [NDIM-1:0][31:0]   hl_q;
  logic [NDIM-1:0][36:0]   hh_q;
  res_t                    res11_q;

  logic [52:0]             kp;
  logic [NDIM-1:0][39:0]   x;
  logic [NDIM-1:0][76:0]   full;
  logic [NDIM-1:0][60:0]   g;
  res_t                    res_d;

  function automatic logic [VAL_W-1:0] sat_val(input logic [60:0] mag, input logic neg);
    logic [VAL_W-1:0] m;
    m = (mag > VMAX) ? VAL_W'(VMAX) : mag[VAL_W-1:0];
    return neg ? (VAL_W'(0) - m) : m;
  endfunction

  assign kp = 53'(s2_i) * 53'(e_i);

  // partial products of x * k, x chosen by mode
  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      x[d] = (item9_q.mode == MODE_HYPER) ? 40'(item9_q.zd[d]) : item9_q.w[d];
    end
  end

  // recombine, shift and saturate
  always_comb begin
    res_d.vals = '0;
    for (int d = 0; d < NDIM; d++) begin
      full[d] = 77'(ll_q[d]) + (77'(lh_q[d]) << 16) + (77'(hl_q[d]) << 24)
              + (77'(hh_q[d]) << 40);
      g[d]    = full[d][76:16];
    end
    unique case (mode10_q)
      MODE_HYPER: begin
        res_d.mode    = MODE_HYPER;
        res_d.vals[0] = sat_val(61'({k10_q, 1'b0}), 1'b0);
        for (int d = 0; d < NDIM; d++) begin
          res_d.vals[d+1] = sat_val(g[d], 1'b0);
        end
      end
      MODE_INPUT: begin
        res_d.mode = MODE_INPUT;
        for (int d = 0; d < NDIM; d++) begin
          res_d.vals[d] = sat_val(g[d], !dneg10_q[d] && (g[d] != '0));
        end
      end
      default: begin
        res_d.mode    = MODE_VALUE;
        res_d.vals[0] = sat_val(61'(k10_q), 1'b0);
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else if (en_i) begin
      v9_q  <= vld_i;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item9_q  <= item_i;
      k9_q     <= kp[52:16];
      k10_q    <= k9_q;
      mode10_q <= item9_q.mode;
      dneg10_q <= item9_q.dneg;
      for (int d = 0; d < NDIM; d++) begin
        ll_q[d] <= 40'(x[d][23:0]) * 40'(k9_q[15:0]);
        lh_q[d] <= 45'(x[d][23:0]) * 45'(k9_q[36:16]);
        hl_q[d] <= 32'(x[d][39:24]) * 32'(k9_q[15:0]);
        hh_q[d] <= 37'(x[d][39:24]) * 37'(k9_q[36:16]);
      end
      res11_q <= res_d;
    end
  end

  assign vld_o = v11_q;
  assign res_o = res11_q;

endmodule

// ----- hdl/ard_squared_exponential_kernel_top.sv -----
// Results of an item pass the front, exp and grad registers and then the
// output sequencer; further results of an item follow in consecutive cycles.
// Value mode takes one item per cycle while the sequencer is not busy with an
// earlier set; in the gradient modes the pipeline is held (busy) by the
// single result port fed from the output sequencer until the set is emitted.
// Reset clears all valid bits and the sequencer control; config registers take their defaults.
// ----------------------------------------------------------------------------
// ard_squared_exponential_kernel_top
// ARD squared exponential kernel: config registers, pipeline, result sequencer.
// ----------------------------------------------------------------------------
module ard_squared_exponential_kernel_top
  import sek_pkg::*;
#(
  parameter int DIMS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] point_a_0_i,
  input  logic signed [15:0] point_a_1_i,
  input  logic signed [15:0] point_a_2_i,
  input  logic signed [15:0] point_a_3_i,
  input  logic signed [15:0] point_b_0_i,
  input  logic signed [15:0] point_b_1_i,
  input  logic signed [15:0] point_b_2_i,
  input  logic signed [15:0] point_b_3_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [25:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [VAL_W-1:0] value_o,
  output logic [2:0]         component_o,
  output logic               last_o
);

  localparam int ND = (DIMS > NDIM) ? NDIM : ((DIMS < 1) ? 1 : DIMS);

  logic [25:0]             amp_q;
  logic [NDIM-1:0][23:0]   inv_q;
  logic [S2_W-1:0]         s2_q;
  logic [51:0]             amp_sq;

  logic [NDIM-1:0][15:0]   pa, pb;
  logic                    en;
  logic                    fv, ev, gv;
  item_t                   fitem, eitem;
  logic [Z_W-1:0]          fz;
  logic [E_W-1:0]          ee;
  res_t                    gres;

  logic [NRES-1:0][VAL_W-1:0] vals_q;
  logic [2:0]              tot_q, pos_q;
  logic [2:0]              tot_d;
  logic [2:0]              remain;
  logic                    emit, stall, load;
  logic                    done_q, last_q;
  logic [VAL_W-1:0]        val_q;
  logic [2:0]              comp_q;

  assign pa = {point_a_3_i, point_a_2_i, point_a_1_i, point_a_0_i};
  assign pb = {point_b_3_i, point_b_2_i, point_b_1_i, point_b_0_i};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= 26'd65536;
      inv_q <= {NDIM{24'd65536}};
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_AMP) begin
        amp_q <= cfg_data_i;
      end else if (cfg_idx_i >= REG_INV0 && cfg_idx_i <= REG_INVL) begin
        inv_q[2'(cfg_idx_i - REG_INV0)] <= cfg_data_i[23:0];
      end
    end
  end

  // squared amplitude, follows the register
  assign amp_sq = 52'(amp_q) * 52'(amp_q);
  always_ff @(posedge clk_i) begin
    s2_q <= amp_sq[51:16];
  end

  // pipeline advances unless the sequencer cannot take the next set
  assign remain = tot_q - pos_q;
  assign emit   = (pos_q != tot_q);
  assign stall  = gv && (remain > 3'd1);
  assign load   = gv && !stall;
  assign en     = !stall;
  assign busy   = stall;

  sek_front #(.ND(ND)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (start && !busy),
    .mode_i (mode_i),
    .pa_i   (pa),
    .pb_i   (pb),
    .inv_i  (inv_q),
    .vld_o  (fv),
    .item_o (fitem),
    .z_o    (fz)
  );

  sek_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fv),
    .item_i (fitem),
    .z_i    (fz),
    .vld_o  (ev),
    .item_o (eitem),
    .e_o    (ee)
  );

  sek_grad u_grad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (ev),
    .item_i (eitem),
    .e_i    (ee),
    .s2_i   (s2_q),
    .vld_o  (gv),
    .res_o  (gres)
  );

  // result count of the incoming set
  always_comb begin
    unique case (gres.mode)
      MODE_HYPER: tot_d = 3'(ND + 1);
      MODE_INPUT: tot_d = 3'(ND);
      default:    tot_d = 3'd1;
    endcase
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= 3'd0;
      pos_q  <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= emit;
      if (load) begin
        tot_q <= tot_d;
        pos_q <= 3'd0;
      end else if (emit) begin
        pos_q <= pos_q + 3'd1;
      end
    end
  end

  // sequencer payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      val_q  <= vals_q[pos_q];
      comp_q <= pos_q;
      last_q <= (pos_q + 3'd1 == tot_q);
    end
    if (load) begin
      vals_q <= gres.vals;
    end
  end

  assign done_o      = done_q;
  assign value_o     = val_q;
  assign component_o = comp_q;
  assign last_o      = last_q;

  // sequencer never runs past its set
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= tot_q)
    else $error("result position beyond set size");

  // a non-final result is always followed by another one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !last_q) |-> (pos_q != tot_q))
    else $error("item results interrupted");

  // while busy the sequencer keeps emitting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (pos_q == $past(pos_q) + 3'd1))
    else $error("stalled without emitting");

  // final result with nothing loaded leaves the port quiet after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (pos_q + 3'd1 == tot_q) && !load) |=> ##1 !done_q)
    else $error("result after final item result");

endmodule
